### design/cdd_pkg.sv
// ----------------------------------------------------------------------------
// cdd_pkg
// Widths, constants and calendar tables shared by the date details pipeline.
// ----------------------------------------------------------------------------
package cdd_pkg;

  localparam int YEAR_W  = 14;
  localparam int MONTH_W = 4;
  localparam int DAY_W   = 5;
  localparam int WD_W    = 3;
  localparam int DOY_W   = 9;
  // year shifted up by 400 for the weekday sum
  localparam int YY_W    = 15;
  // quotient of the shifted year (at most 16783) by 100
  localparam int Q_W     = 8;
  localparam int SUM_W   = 15;

  // x / 100 == (x * DIV100_MUL) >> DIV100_SH, exact for x < 2**15
  localparam int DIV100_MUL_W = 13;
  localparam logic [DIV100_MUL_W-1:0] DIV100_MUL = 13'd5243;
  localparam int DIV100_SH = 19;

  localparam logic [YY_W-1:0]    YEAR_SHIFT = 15'd400;
  localparam logic [MONTH_W-1:0] MONTH_FEB  = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_DEC  = 4'd12;
  localparam logic [WD_W-1:0]    WD_FRIDAY  = 3'd5;
  localparam logic [WD_W-1:0]    WD_SATURDAY = 3'd6;
  localparam logic [WD_W-1:0]    WD_MOD     = 3'd7;
  localparam logic [DOY_W-1:0]   DAYS_COMMON = 9'd365;
  localparam logic [DOY_W-1:0]   DAYS_LEAP   = 9'd366;

  // days before the first of the month, common year
  function automatic logic [DOY_W-1:0] days_before(input logic [MONTH_W-1:0] m);
    logic [DOY_W-1:0] d;
    case (m)
      4'd1:    d = 9'd0;
      4'd2:    d = 9'd31;
      4'd3:    d = 9'd59;
      4'd4:    d = 9'd90;
      4'd5:    d = 9'd120;
      4'd6:    d = 9'd151;
      4'd7:    d = 9'd181;
      4'd8:    d = 9'd212;
      4'd9:    d = 9'd243;
      4'd10:   d = 9'd273;
      4'd11:   d = 9'd304;
      4'd12:   d = 9'd334;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

  // month length; zero for a month number outside 1..12
  function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] m,
                                                  input logic leap);
    logic [DAY_W-1:0] d;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: d = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                  d = 5'd30;
      4'd2:    d = leap ? 5'd29 : 5'd28;
      default: d = 5'd0;
    endcase
    return d;
  endfunction

  // (31 * mm) / 12 for the shifted month number mm
  function automatic logic [DAY_W-1:0] month_term(input logic [MONTH_W-1:0] mm);
    logic [DAY_W-1:0] t;
    case (mm)
      4'd1:    t = 5'd2;
      4'd2:    t = 5'd5;
      4'd3:    t = 5'd7;
      4'd4:    t = 5'd10;
      4'd5:    t = 5'd12;
      4'd6:    t = 5'd15;
      4'd7:    t = 5'd18;
      4'd8:    t = 5'd20;
      4'd9:    t = 5'd23;
      4'd10:   t = 5'd25;
      4'd11:   t = 5'd28;
      4'd12:   t = 5'd31;
      default: t = 5'd0;
    endcase
    return t;
  endfunction

endpackage

### design/cdd_mod7.sv
// ----------------------------------------------------------------------------
// cdd_mod7
// Residue of the weekday sum modulo 7 by folding octal digits (8 == 1 mod 7).
// ----------------------------------------------------------------------------
module cdd_mod7
  import cdd_pkg::*;
(
  input  logic [SUM_W-1:0] sum,
  output logic [WD_W-1:0]  residue
);

  logic [5:0] fold1;
  logic [3:0] fold2;
  logic [3:0] fold3;

  always_comb begin
    fold1 = 6'(sum[14:12]) + 6'(sum[11:9]) + 6'(sum[8:6]) + 6'(sum[5:3])
          + 6'(sum[2:0]);
    fold2 = 4'(fold1[5:3]) + 4'(fold1[2:0]);
    fold3 = 4'(fold2[3]) + 4'(fold2[2:0]);
    // fold3 is at most 7 here
    if (fold3 >= 4'(WD_MOD)) begin
      residue = WD_W'(fold3 - 4'(WD_MOD));
    end else begin
      residue = fold3[WD_W-1:0];
    end
  end

endmodule

### design/calendar_date_details.sv
// ----------------------------------------------------------------------------
// calendar_date_details
// Gregorian date to weekday, leap flag, weekend flags and days remaining.
// ----------------------------------------------------------------------------
// Takes one date per cycle while out_stall is low, and returns its result
// through four register stages: month shift and shifted year, the
// two divide-by-100 reciprocal multiplies, the leap test with the weekday sum
// and day-of-year, and the mod-7 fold into the output register. A stage
// advances whenever the stage after it is empty or moving, so a stall on the
// output fills the pipe before in_stall rises and nothing is dropped. An
// invalid month or day gives date_invalid high with every other field zero.
module calendar_date_details
  import cdd_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [YEAR_W-1:0]   in_year,
  input  logic [MONTH_W-1:0]  in_month,
  input  logic [DAY_W-1:0]    in_day,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [WD_W-1:0]     out_weekday,
  output logic                out_leap_year,
  output logic                out_end_of_week,
  output logic                out_weekend,
  output logic                out_business_day,
  output logic [WD_W-1:0]     out_days_to_week_end,
  output logic [DAY_W-1:0]    out_days_to_month_end,
  output logic [DOY_W-1:0]    out_days_to_year_end,
  output logic                out_date_invalid
);

  localparam int PY_W  = YEAR_W + DIV100_MUL_W;
  localparam int PYY_W = YY_W + DIV100_MUL_W;

  // stage enables, back to front
  logic en1, en2, en3, en4;

  // ---------------- stage 1: shifted month and year ----------------
  logic                s1_valid_r;
  logic [YEAR_W-1:0]   s1_year_r;
  logic [MONTH_W-1:0]  s1_month_r;
  logic [DAY_W-1:0]    s1_day_r;
  logic [YY_W-1:0]     s1_yy_r, s1_yy_nxt;
  logic [MONTH_W-1:0]  s1_mm_r, s1_mm_nxt;
  logic                jan_feb;

  // ---------------- stage 2: quotients by 100 ----------------
  logic                s2_valid_r;
  logic [YEAR_W-1:0]   s2_year_r;
  logic [MONTH_W-1:0]  s2_month_r;
  logic [DAY_W-1:0]    s2_day_r;
  logic [YY_W-1:0]     s2_yy_r;
  logic [MONTH_W-1:0]  s2_mm_r;
  logic [Q_W-1:0]      s2_qy_r, s2_qy_nxt;
  logic [Q_W-1:0]      s2_qyy_r, s2_qyy_nxt;
  logic [PY_W-1:0]     prod_y;
  logic [PYY_W-1:0]    prod_yy;

  // ---------------- stage 3: leap, sum, remaining days ----------------
  logic                s3_valid_r;
  logic [SUM_W-1:0]    s3_sum_r, s3_sum_nxt;
  logic                s3_leap_r, s3_leap_nxt;
  logic                s3_invalid_r, s3_invalid_nxt;
  logic [DAY_W-1:0]    s3_dtme_r, s3_dtme_nxt;
  logic [DOY_W-1:0]    s3_dtye_r, s3_dtye_nxt;
  logic                cent;
  logic [DAY_W-1:0]    dim;
  logic [DOY_W-1:0]    doy;

  // ---------------- stage 4: output register ----------------
  logic                out_valid_r;
  logic [WD_W-1:0]     wd;
  logic [WD_W-1:0]     weekday_r, weekday_nxt;
  logic                leap_r, leap_nxt;
  logic                eow_r, eow_nxt;
  logic                wkend_r, wkend_nxt;
  logic                busy_r, busy_nxt;
  logic [WD_W-1:0]     dtwe_r, dtwe_nxt;
  logic [DAY_W-1:0]    dtme_r, dtme_nxt;
  logic [DOY_W-1:0]    dtye_r, dtye_nxt;
  logic                invalid_r, invalid_nxt;

  assign en4 = !out_valid_r || !out_stall;
  assign en3 = !s3_valid_r  || en4;
  assign en2 = !s2_valid_r  || en3;
  assign en1 = !s1_valid_r  || en2;
  assign in_stall = !en1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      s3_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (en1) s1_valid_r  <= in_valid;
      if (en2) s2_valid_r  <= s1_valid_r;
      if (en3) s3_valid_r  <= s2_valid_r;
      if (en4) out_valid_r <= s3_valid_r;
    end
  end

  // stage 1
  always_comb begin
    jan_feb   = (in_month <= MONTH_FEB);
    s1_yy_nxt = YY_W'(in_year) + YEAR_SHIFT - YY_W'(jan_feb);
    s1_mm_nxt = jan_feb ? (in_month + 4'd10) : (in_month - 4'd2);
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      s1_year_r  <= in_year;
      s1_month_r <= in_month;
      s1_day_r   <= in_day;
      s1_yy_r    <= s1_yy_nxt;
      s1_mm_r    <= s1_mm_nxt;
    end
  end

  // stage 2
  always_comb begin
    prod_y     = PY_W'(s1_year_r) * PY_W'(DIV100_MUL);
    prod_yy    = PYY_W'(s1_yy_r) * PYY_W'(DIV100_MUL);
    s2_qy_nxt  = prod_y[DIV100_SH +: Q_W];
    s2_qyy_nxt = prod_yy[DIV100_SH +: Q_W];
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      s2_year_r  <= s1_year_r;
      s2_month_r <= s1_month_r;
      s2_day_r   <= s1_day_r;
      s2_yy_r    <= s1_yy_r;
      s2_mm_r    <= s1_mm_r;
      s2_qy_r    <= s2_qy_nxt;
      s2_qyy_r   <= s2_qyy_nxt;
    end
  end

  // stage 3
  always_comb begin
    cent = (YY_W'(s2_year_r) == YY_W'(s2_qy_r) * YY_W'(100));
    s3_leap_nxt = (s2_year_r[1:0] == 2'd0 && !cent) || (cent && s2_qy_r[1:0] == 2'd0);
    dim = month_days(s2_month_r, s3_leap_nxt);
    s3_invalid_nxt = (dim == '0) || (s2_day_r == '0) || (s2_day_r > dim);
    doy = days_before(s2_month_r) + DOY_W'(s2_day_r)
        + DOY_W'(s3_leap_nxt && s2_month_r > MONTH_FEB);
    s3_dtme_nxt = dim - s2_day_r;
    s3_dtye_nxt = (s3_leap_nxt ? DAYS_LEAP : DAYS_COMMON) - doy;
    s3_sum_nxt  = SUM_W'(s2_day_r) + s2_yy_r + SUM_W'(s2_yy_r >> 2)
                - SUM_W'(s2_qyy_r) + SUM_W'(s2_qyy_r >> 2)
                + SUM_W'(month_term(s2_mm_r));
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      s3_sum_r     <= s3_sum_nxt;
      s3_leap_r    <= s3_leap_nxt;
      s3_invalid_r <= s3_invalid_nxt;
      s3_dtme_r    <= s3_dtme_nxt;
      s3_dtye_r    <= s3_dtye_nxt;
    end
  end

  // stage 4
  cdd_mod7 u_mod7 (
    .sum     (s3_sum_r),
    .residue (wd)
  );

  always_comb begin
    invalid_nxt = s3_invalid_r;
    weekday_nxt = '0;
    leap_nxt    = 1'b0;
    eow_nxt     = 1'b0;
    wkend_nxt   = 1'b0;
    busy_nxt    = 1'b0;
    dtwe_nxt    = '0;
    dtme_nxt    = '0;
    dtye_nxt    = '0;
    if (!s3_invalid_r) begin
      weekday_nxt = wd;
      leap_nxt    = s3_leap_r;
      eow_nxt     = (wd == WD_SATURDAY);
      wkend_nxt   = (wd == WD_FRIDAY) || (wd == WD_SATURDAY);
      busy_nxt    = !wkend_nxt;
      dtwe_nxt    = WD_SATURDAY - wd;
      dtme_nxt    = s3_dtme_r;
      dtye_nxt    = s3_dtye_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en4) begin
      weekday_r <= weekday_nxt;
      leap_r    <= leap_nxt;
      eow_r     <= eow_nxt;
      wkend_r   <= wkend_nxt;
      busy_r    <= busy_nxt;
      dtwe_r    <= dtwe_nxt;
      dtme_r    <= dtme_nxt;
      dtye_r    <= dtye_nxt;
      invalid_r <= invalid_nxt;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_weekday           = weekday_r;
  assign out_leap_year         = leap_r;
  assign out_end_of_week       = eow_r;
  assign out_weekend           = wkend_r;
  assign out_business_day      = busy_r;
  assign out_days_to_week_end  = dtwe_r;
  assign out_days_to_month_end = dtme_r;
  assign out_days_to_year_end  = dtye_r;
  assign out_date_invalid      = invalid_r;

`ifndef ASSERT_OFF
  // input side only backs up once every stage holds a transfer
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid_r && s3_valid_r && s2_valid_r && s1_valid_r))
    else $error("in_stall raised with a bubble in the pipe");

  // an invalid date carries no other information
  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && invalid_r) |-> (weekday_r == '0 && !leap_r && !busy_r
      && dtme_r == '0 && dtye_r == '0 && dtwe_r == '0))
    else $error("invalid date with nonzero fields");

  a_week_sum: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !invalid_r) |-> (weekday_r <= WD_SATURDAY
      && 4'(weekday_r) + 4'(dtwe_r) == 4'(WD_SATURDAY)))
    else $error("weekday and days to week end disagree");

  a_flags: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !invalid_r) |-> (busy_r != wkend_r && (!eow_r || wkend_r)))
    else $error("weekend flags inconsistent");

  // a stalled stage three holds its transfer into the next cycle
  a_s3_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s3_valid_r && !en3) |=> (s3_valid_r && $stable(s3_sum_r)))
    else $error("stage three lost a held transfer");
`endif

endmodule

### sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for calendar_date_details. Dates go in through a
// valid/stall sender with random gaps. Each transfer is scored against a
// behavioral calendar computed in the bench, in order, while the output side
// is stalled at random.
// ----------------------------------------------------------------------------
module tb_top;
  import cdd_pkg::*;

  localparam int  MAX_CYCLES = 200000;
  localparam int  DRAIN_CYCLES = 16;

  typedef struct packed {
    logic [WD_W-1:0]  weekday;
    logic             leap_year;
    logic             end_of_week;
    logic             weekend;
    logic             business_day;
    logic [WD_W-1:0]  days_to_week_end;
    logic [DAY_W-1:0] days_to_month_end;
    logic [DOY_W-1:0] days_to_year_end;
    logic             date_invalid;
  } date_info_t;

  typedef struct {
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
    date_info_t         info;
  } pending_date_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [YEAR_W-1:0]   in_year = '0;
  logic [MONTH_W-1:0]  in_month = '0;
  logic [DAY_W-1:0]    in_day = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [WD_W-1:0]     out_weekday;
  logic                out_leap_year;
  logic                out_end_of_week;
  logic                out_weekend;
  logic                out_business_day;
  logic [WD_W-1:0]     out_days_to_week_end;
  logic [DAY_W-1:0]    out_days_to_month_end;
  logic [DOY_W-1:0]    out_days_to_year_end;
  logic                out_date_invalid;

  pending_date_t pending_q[$];
  int unsigned   err_cnt = 0;
  int unsigned   cycle_cnt = 0;
  int unsigned   send_gap_pct = 0;
  int unsigned   recv_stall_pct = 0;

  always #2 clk = ~clk;

  calendar_date_details u_top (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_stall              (in_stall),
    .in_year               (in_year),
    .in_month              (in_month),
    .in_day                (in_day),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_weekday           (out_weekday),
    .out_leap_year         (out_leap_year),
    .out_end_of_week       (out_end_of_week),
    .out_weekend           (out_weekend),
    .out_business_day      (out_business_day),
    .out_days_to_week_end  (out_days_to_week_end),
    .out_days_to_month_end (out_days_to_month_end),
    .out_days_to_year_end  (out_days_to_year_end),
    .out_date_invalid      (out_date_invalid)
  );

  // --------------------------------------------------------------------------
  // Calendar arithmetic
  // --------------------------------------------------------------------------
  function automatic bit is_leap_year(int unsigned yr);
    return ((yr % 4 == 0) && (yr % 100 != 0)) || (yr % 400 == 0);
  endfunction

  function automatic int unsigned month_len(int unsigned yr, int unsigned mo);
    int unsigned len;
    case (mo)
      1, 3, 5, 7, 8, 10, 12: len = 31;
      4, 6, 9, 11:           len = 30;
      MONTH_FEB:             len = is_leap_year(yr) ? 29 : 28;
      default:               len = 0;
    endcase
    return len;
  endfunction

  function automatic date_info_t calc_date_info(logic [YEAR_W-1:0] y,
                                                logic [MONTH_W-1:0] m,
                                                logic [DAY_W-1:0] d);
    date_info_t  r;
    int unsigned yr, mo, dy, len, a, yy, mm, sum, wd, doy, diy;
    bit          leap;
    r = '0;
    yr = y;
    mo = m;
    dy = d;
    len = month_len(yr, mo);
    if (len == 0 || dy < 1 || dy > len) begin
      r.date_invalid = 1'b1;
      return r;
    end
    leap = is_leap_year(yr);
    // March-based month numbering; the +400 keeps year 0 January in range
    a = (14 - mo) / 12;
    yy = yr + 400 - a;
    mm = mo + 12 * a - 2;
    sum = dy + yy + yy / 4 - yy / 100 + yy / 400 + (31 * mm) / 12;
    wd = sum % 7;
    doy = dy;
    for (int k = 1; k < mo; k++) doy += month_len(yr, k);
    diy = leap ? 366 : 365;
    r.weekday = WD_W'(wd);
    r.leap_year = leap;
    r.end_of_week = (wd == WD_SATURDAY);
    r.weekend = (wd == WD_FRIDAY) || (wd == WD_SATURDAY);
    r.business_day = !r.weekend;
    r.days_to_week_end = WD_W'(6 - wd);
    r.days_to_month_end = DAY_W'(len - dy);
    r.days_to_year_end = DOY_W'(diy - doy);
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Sender
  // --------------------------------------------------------------------------
  task automatic send_date(int unsigned yr, int unsigned mo, int unsigned dy);
    pending_date_t p;
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_year  <= yr[YEAR_W-1:0];
    in_month <= mo[MONTH_W-1:0];
    in_day   <= dy[DAY_W-1:0];
    @(posedge clk);
    while (in_stall) @(posedge clk);
    p.year  = yr[YEAR_W-1:0];
    p.month = mo[MONTH_W-1:0];
    p.day   = dy[DAY_W-1:0];
    p.info  = calc_date_info(p.year, p.month, p.day);
    pending_q.push_back(p);
  endtask

  task automatic set_idling(int unsigned gap_pct, int unsigned stall_pct);
    send_gap_pct = gap_pct;
    recv_stall_pct = stall_pct;
  endtask

  // --------------------------------------------------------------------------
  // Receiver and scoreboard
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  function automatic void check_field(string name, pending_date_t p,
                                      int unsigned exp_v, int unsigned act_v);
    if (exp_v != act_v) begin
      err_cnt++;
      $display("%0t: %0d-%0d-%0d %s expected %0d, actual %0d",
               $time, p.year, p.month, p.day, name, exp_v, act_v);
    end
  endfunction

  always @(posedge clk) begin
    pending_date_t p;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_q.size() == 0) begin
        err_cnt++;
        $display("%0t: unexpected result transfer, expected none, actual weekday %0d",
                 $time, out_weekday);
      end else begin
        p = pending_q.pop_front();
        check_field("weekday", p, 32'(p.info.weekday), 32'(out_weekday));
        check_field("leap_year", p, 32'(p.info.leap_year), 32'(out_leap_year));
        check_field("end_of_week", p, 32'(p.info.end_of_week),
                    32'(out_end_of_week));
        check_field("weekend", p, 32'(p.info.weekend), 32'(out_weekend));
        check_field("business_day", p, 32'(p.info.business_day),
                    32'(out_business_day));
        check_field("days_to_week_end", p, 32'(p.info.days_to_week_end),
                    32'(out_days_to_week_end));
        check_field("days_to_month_end", p, 32'(p.info.days_to_month_end),
                    32'(out_days_to_month_end));
        check_field("days_to_year_end", p, 32'(p.info.days_to_year_end),
                    32'(out_days_to_year_end));
        check_field("date_invalid", p, 32'(p.info.date_invalid),
                    32'(out_date_invalid));
      end
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  task automatic test_directed_dates();
    send_date(1, 1, 1);
    send_date(9999, 12, 31);
    send_date(2000, 2, 29);      // leap by the 400 rule
    send_date(1900, 2, 29);      // century, not leap
    send_date(1900, 2, 28);
    send_date(2024, 2, 29);
    send_date(2023, 2, 29);
    send_date(2024, 12, 31);
    send_date(2024, 1, 1);       // longest run to year end
    send_date(2023, 4, 31);
    send_date(2023, 4, 30);
    send_date(0, 1, 1);          // year zero, Jan/Feb use the shifted year
    send_date(0, 2, 29);
    send_date(16383, 15, 31);
    send_date(16383, 12, 31);
    send_date(2023, 0, 10);
    send_date(2023, 13, 1);
    send_date(2023, 5, 0);
    // one full week, Sunday through Saturday
    for (int k = 1; k <= 7; k++) send_date(2023, 1, k);
  endtask

  task automatic test_invalid_dates(int n);
    int unsigned yr, mo, dy, len;
    for (int k = 0; k < n; k++) begin
      yr = $urandom_range(16383);
      case ($urandom_range(2))
        0: begin
          mo = ($urandom_range(3) == 0) ? 0 : $urandom_range(15, 13);
          dy = $urandom_range(31);
        end
        1: begin
          mo = $urandom_range(12, 1);
          dy = 0;
        end
        default: begin
          mo = $urandom_range(12, 1);
          len = month_len(yr, mo);
          dy = $urandom_range(31, len + 1);
          if (len == 31) dy = 0;
        end
      endcase
      send_date(yr, mo, dy);
    end
  endtask

  task automatic test_leap_years(int n);
    int unsigned yr;
    for (int k = 0; k < n; k++) begin
      yr = $urandom_range(99) * 100 + (($urandom_range(1) == 0) ? 0 : 4 * $urandom_range(24));
      case ($urandom_range(2))
        0:       send_date(yr, 2, 28 + $urandom_range(1));
        1:       send_date(yr, 12, 31);
        default: send_date(yr, 3, 1);
      endcase
    end
  endtask

  task automatic test_random_dates(int n);
    int unsigned yr, mo, dy, sel;
    for (int k = 0; k < n; k++) begin
      sel = $urandom_range(99);
      if (sel < 75) begin
        yr = $urandom_range(9999, 1);
        mo = $urandom_range(12, 1);
        dy = $urandom_range(month_len(yr, mo), 1);
      end else if (sel < 90) begin
        // years the calendar does not nominally cover
        yr = $urandom_range(16383);
        mo = $urandom_range(12, 1);
        dy = $urandom_range(month_len(yr, mo), 1);
      end else begin
        yr = $urandom_range(16383);
        mo = $urandom_range(15);
        dy = $urandom_range(31);
      end
      send_date(yr, mo, dy);
    end
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    set_idling(17, 84);
    test_directed_dates();
    test_invalid_dates(40);
    test_random_dates(110);
    set_idling(84, 17);
    test_leap_years(30);
    test_random_dates(110);
    set_idling(0, 0);
    test_random_dates(110);
    in_valid <= 1'b0;

    while (pending_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_cnt == 0 && pending_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    while (cycle_cnt < MAX_CYCLES) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("timeout after %0d cycles, %0d results outstanding",
             cycle_cnt, pending_q.size());
    $display("Regression FAIL");
    $finish;
  end

endmodule
